@@ rtl/smpg_pkg.sv @@
// shared types, constants and codes of the step/direction pulse generator
package smpg_pkg;

  localparam int HALF_PERIOD_BITS = 24;
  localparam int POSITION_BITS    = 32;
  localparam int MIN_MOVE_PULSES  = 2;
  localparam int PHASE_BITS       = HALF_PERIOD_BITS + 1;
  localparam int AMOUNT_BITS      = 32;
  localparam int POS_OUT_BITS     = 32;
  localparam int ACTION_BITS      = 3;
  localparam int STATUS_BITS      = 2;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 24;

  localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RST     = HALF_PERIOD_BITS'(1000);
  localparam logic [HALF_PERIOD_BITS-1:0] MIN_HALF_PERIOD_RST = HALF_PERIOD_BITS'(1);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK    = 3'd0,
    ACT_REL     = 3'd1,
    ACT_ABS     = 3'd2,
    ACT_SET_POS = 3'd3,
    ACT_STOP    = 3'd4
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HALF_PERIOD     = 2'd0,
    REG_MIN_HALF_PERIOD = 2'd1,
    REG_DIR_POLARITY    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                     direction;
    logic                     dir_pin;
    logic                     too_short;
    logic [POSITION_BITS-1:0] magnitude;
  } move_dec_t;

  typedef struct packed {
    logic                           step_level;
    logic                           dir_level;
    logic                           busy_res;
    logic                           done_res;
    logic signed [POS_OUT_BITS-1:0] position;
    status_t                        status;
  } result_t;

endpackage

@@ rtl/smpg_in_if.sv @@
// command channel of the pulse generator
interface smpg_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [smpg_pkg::ACTION_BITS-1:0]       action;
  logic signed [smpg_pkg::AMOUNT_BITS-1:0] amount;

  modport source (output valid, output action, output amount, input ready);
  modport sink (input valid, input action, input amount, output ready);
endinterface

@@ rtl/smpg_out_if.sv @@
// result channel of the pulse generator
interface smpg_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     step_level;
  logic                                     dir_level;
  logic                                     busy_res;
  logic                                     done_res;
  logic signed [smpg_pkg::POS_OUT_BITS-1:0] position;
  logic [smpg_pkg::STATUS_BITS-1:0]         status;

  modport source (output valid, output step_level, output dir_level, output busy_res,
                  output done_res, output position, output status, input ready);
  modport sink (input valid, input step_level, input dir_level, input busy_res,
                input done_res, input position, input status, output ready);
endinterface

@@ rtl/smpg_move_calc.sv @@
// move decode: direction, direction pin, pulse magnitude and minimum length check
module smpg_move_calc (
  input  logic signed [smpg_pkg::POSITION_BITS-1:0] distance,
  input  logic                                      dir_polarity,
  output smpg_pkg::move_dec_t                       dec
);

  logic                               neg;
  logic                               dir;
  logic [smpg_pkg::POSITION_BITS-1:0] mag;

  always_comb begin
    neg = distance[smpg_pkg::POSITION_BITS-1];
    dir = !neg && (distance != '0);
    // negation of the most negative value keeps its pattern, which is its magnitude
    mag = neg ? (~distance + 1'b1) : distance;
    dec.direction = dir;
    dec.dir_pin   = dir_polarity ? dir : !dir;
    dec.magnitude = mag;
    dec.too_short = mag < smpg_pkg::POSITION_BITS'(smpg_pkg::MIN_MOVE_PULSES);
  end

endmodule

@@ rtl/stepper_move_pulse_generator.sv @@
// top level of the stepper step/direction pulse generator
//
// in_ch carries one command per transaction: tick, relative move, absolute
// move, set position or stop, with a signed 32-bit amount. out_ch returns
// exactly one result per command: step and direction pin levels, busy, done,
// position and a status code (accepted, rejected busy, rejected too short).
// cfg_we/cfg_index/cfg_wdata write half_period, min_half_period and
// dir_polarity; write only while no command is in flight.
//
// a command is registered at acceptance and its result is registered once the
// result register is free, when out_ch.valid rises.
// throughput is one command per cycle while out_ch does not stall: the
// combinational state update (phase counter add and compare, position and
// pulse count decrement) sets it. when out_ch stalls, the result register
// holds and in_ch.ready is high only while the input register is empty.
// synchronous reset clears position, pulse count, phase, motion and
// direction, sets the direction pin high and restores register defaults.
module stepper_move_pulse_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  smpg_in_if.sink                               in_ch,
  smpg_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [smpg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [smpg_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int PB = smpg_pkg::POSITION_BITS;
  localparam int HB = smpg_pkg::HALF_PERIOD_BITS;
  localparam int QB = smpg_pkg::PHASE_BITS;

  // configuration
  logic [HB-1:0] half_period_r;
  logic [HB-1:0] min_half_period_r;
  logic          dir_polarity_r;

  // input register
  logic                                     s1_valid_r;
  logic [smpg_pkg::ACTION_BITS-1:0]         s1_action_r;
  logic signed [smpg_pkg::AMOUNT_BITS-1:0]  s1_amount_r;

  // motion state
  logic signed [PB-1:0] cur_pos_r, cur_pos_nxt;
  logic [PB-1:0]        pulses_r, pulses_nxt;
  logic [QB-1:0]        phase_r, phase_nxt;
  logic                 moving_r, moving_nxt;
  logic                 direction_r, direction_nxt;
  logic                 dir_pin_r, dir_pin_nxt;

  // result register
  logic                out_valid_r;
  smpg_pkg::result_t   out_data_r, out_data_nxt;

  logic                 out_free;
  logic                 adv;
  logic [HB-1:0]        eff_half;
  logic signed [PB-1:0] amount_pos;
  logic signed [PB-1:0] distance;
  logic [QB-1:0]        phase_inc;
  logic [PB-1:0]        pulses_dec;
  smpg_pkg::move_dec_t  move_dec;
  smpg_pkg::status_t    status;
  logic                 done;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign adv          = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.step_level = out_data_r.step_level;
  assign out_ch.dir_level  = out_data_r.dir_level;
  assign out_ch.busy_res   = out_data_r.busy_res;
  assign out_ch.done_res   = out_data_r.done_res;
  assign out_ch.position   = out_data_r.position;
  assign out_ch.status     = out_data_r.status;

  always_comb begin
    if (half_period_r > min_half_period_r) begin
      eff_half = half_period_r;
    end else if (min_half_period_r == '0) begin
      eff_half = HB'(1);
    end else begin
      eff_half = min_half_period_r;
    end
  end

  assign amount_pos = PB'(s1_amount_r);
  assign distance   = (s1_action_r == smpg_pkg::ACT_ABS) ? (amount_pos - cur_pos_r)
                                                         : amount_pos;

  smpg_move_calc u_move_calc (
    .distance     (distance),
    .dir_polarity (dir_polarity_r),
    .dec          (move_dec)
  );

  assign phase_inc  = phase_r + 1'b1;
  assign pulses_dec = pulses_r - 1'b1;

  always_comb begin
    cur_pos_nxt   = cur_pos_r;
    pulses_nxt    = pulses_r;
    phase_nxt     = phase_r;
    moving_nxt    = moving_r;
    direction_nxt = direction_r;
    dir_pin_nxt   = dir_pin_r;
    status        = smpg_pkg::ST_OK;
    done          = 1'b0;
    unique case (s1_action_r)
      smpg_pkg::ACT_TICK: begin
        if (moving_r) begin
          if (phase_inc >= {eff_half, 1'b0}) begin
            phase_nxt   = '0;
            cur_pos_nxt = direction_r ? (cur_pos_r + 1'b1) : (cur_pos_r - 1'b1);
            pulses_nxt  = pulses_dec;
            if (pulses_dec == '0) begin
              moving_nxt = 1'b0;
              done       = 1'b1;
            end
          end else begin
            phase_nxt = phase_inc;
          end
        end
      end
      smpg_pkg::ACT_REL, smpg_pkg::ACT_ABS: begin
        if (moving_r) begin
          status = smpg_pkg::ST_BUSY;
        end else begin
          direction_nxt = move_dec.direction;
          dir_pin_nxt   = move_dec.dir_pin;
          if (move_dec.too_short) begin
            status = smpg_pkg::ST_SHORT;
          end else begin
            pulses_nxt = move_dec.magnitude;
            phase_nxt  = '0;
            moving_nxt = 1'b1;
          end
        end
      end
      smpg_pkg::ACT_SET_POS: begin
        if (moving_r) begin
          status = smpg_pkg::ST_BUSY;
        end else begin
          cur_pos_nxt = amount_pos;
        end
      end
      smpg_pkg::ACT_STOP: begin
        moving_nxt = 1'b0;
        pulses_nxt = '0;
        phase_nxt  = '0;
      end
      default: begin
        status = smpg_pkg::ST_OK;
      end
    endcase

    out_data_nxt.step_level = moving_nxt && (phase_nxt < {1'b0, eff_half});
    out_data_nxt.dir_level  = dir_pin_nxt;
    out_data_nxt.busy_res   = moving_nxt;
    out_data_nxt.done_res   = done;
    out_data_nxt.position   = smpg_pkg::POS_OUT_BITS'(cur_pos_nxt);
    out_data_nxt.status     = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r     <= smpg_pkg::HALF_PERIOD_RST;
      min_half_period_r <= smpg_pkg::MIN_HALF_PERIOD_RST;
      dir_polarity_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smpg_pkg::REG_HALF_PERIOD:     half_period_r     <= HB'(cfg_wdata);
        smpg_pkg::REG_MIN_HALF_PERIOD: min_half_period_r <= HB'(cfg_wdata);
        smpg_pkg::REG_DIR_POLARITY:    dir_polarity_r    <= cfg_wdata[0];
        default: begin
          dir_polarity_r <= dir_polarity_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action_r <= in_ch.action;
      s1_amount_r <= in_ch.amount;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r   <= '0;
      pulses_r    <= '0;
      phase_r     <= '0;
      moving_r    <= 1'b0;
      direction_r <= 1'b0;
      dir_pin_r   <= 1'b1;
    end else if (adv) begin
      cur_pos_r   <= cur_pos_nxt;
      pulses_r    <= pulses_nxt;
      phase_r     <= phase_nxt;
      moving_r    <= moving_nxt;
      direction_r <= direction_nxt;
      dir_pin_r   <= dir_pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_done_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  a_step_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.step_level) |-> out_data_r.busy_res)
    else $error("step level high while idle");

  a_busy_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && status == smpg_pkg::ST_BUSY) |=> ($stable(cur_pos_r) && $stable(pulses_r)))
    else $error("busy rejection changed motion state");

  a_moving_has_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (pulses_r != '0))
    else $error("moving with no pulses left");

  a_no_adv_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(cur_pos_r) && $stable(moving_r) && $stable(phase_r)))
    else $error("motion state changed without a transaction");

endmodule

@@ tb/stepper_move_pulse_generator_tb.sv @@
// testbench for the stepper step/direction pulse generator: directed and random commands
`timescale 1ns / 100ps

module stepper_move_pulse_generator_tb;
  import smpg_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam logic [ACTION_BITS-1:0] ACT_UNDEFINED = ACTION_BITS'(ACT_STOP) + 1'b1;

  class axis_scoreboard;
    logic [HALF_PERIOD_BITS-1:0] cfg_half;
    logic [HALF_PERIOD_BITS-1:0] cfg_floor;
    logic                        cfg_pol;
    logic [POSITION_BITS-1:0]    axis_pos;
    logic [POSITION_BITS-1:0]    steps_to_go;
    logic [PHASE_BITS-1:0]       phase_ticks;
    logic                        in_motion;
    logic                        heading_up;
    logic                        dir_out;
    result_t                     axis_reports[$];
    int                          errors;

    function new();
      cfg_half    = HALF_PERIOD_RST;
      cfg_floor   = MIN_HALF_PERIOD_RST;
      cfg_pol     = 1'b0;
      axis_pos    = '0;
      steps_to_go = '0;
      phase_ticks = '0;
      in_motion   = 1'b0;
      heading_up  = 1'b0;
      dir_out     = 1'b1;
      errors      = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_HALF_PERIOD:     cfg_half = value[HALF_PERIOD_BITS-1:0];
        REG_MIN_HALF_PERIOD: cfg_floor = value[HALF_PERIOD_BITS-1:0];
        REG_DIR_POLARITY:    cfg_pol = value[0];
        default: ;
      endcase
    endfunction

    function logic [HALF_PERIOD_BITS-1:0] pulse_half();
      logic [HALF_PERIOD_BITS-1:0] hv;
      hv = (cfg_half > cfg_floor) ? cfg_half : cfg_floor;
      if (hv == '0) hv = HALF_PERIOD_BITS'(1);
      return hv;
    endfunction

    function status_t launch_move(logic [POSITION_BITS-1:0] travel);
      logic [POSITION_BITS-1:0] mag;
      if (in_motion) return ST_BUSY;
      heading_up = !travel[POSITION_BITS-1] && (travel != '0);
      dir_out = cfg_pol ? heading_up : !heading_up;
      mag = travel[POSITION_BITS-1] ? (~travel + 1'b1) : travel;
      if (mag < MIN_MOVE_PULSES) return ST_SHORT;
      steps_to_go = mag;
      phase_ticks = '0;
      in_motion = 1'b1;
      return ST_OK;
    endfunction

    function void advance_axis(logic [ACTION_BITS-1:0] act, logic [AMOUNT_BITS-1:0] amt);
      logic [HALF_PERIOD_BITS-1:0] h;
      status_t                     st;
      logic                        done;
      result_t                     r;
      h = pulse_half();
      st = ST_OK;
      done = 1'b0;
      case (act)
        ACT_TICK: begin
          if (in_motion) begin
            phase_ticks = phase_ticks + 1'b1;
            if (phase_ticks >= {h, 1'b0}) begin
              phase_ticks = '0;
              axis_pos = heading_up ? axis_pos + 1'b1 : axis_pos - 1'b1;
              steps_to_go = steps_to_go - 1'b1;
              if (steps_to_go == '0) begin
                in_motion = 1'b0;
                done = 1'b1;
              end
            end
          end
        end
        ACT_REL: st = launch_move(amt);
        ACT_ABS: st = launch_move(amt - axis_pos);
        ACT_SET_POS: begin
          if (in_motion) st = ST_BUSY;
          else axis_pos = amt;
        end
        ACT_STOP: begin
          in_motion = 1'b0;
          steps_to_go = '0;
          phase_ticks = '0;
        end
        default: ;
      endcase
      r.step_level = in_motion && (phase_ticks < h);
      r.dir_level  = dir_out;
      r.busy_res   = in_motion;
      r.done_res   = done;
      r.position   = axis_pos;
      r.status     = st;
      axis_reports.push_back(r);
    endfunction

    function string describe(result_t r);
      return $sformatf("step=%0b dir=%0b busy=%0b done=%0b pos=%0d status=%0d",
                       r.step_level, r.dir_level, r.busy_res, r.done_res,
                       r.position, r.status);
    endfunction

    function void compare_report(result_t got);
      result_t want;
      if (axis_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = axis_reports.pop_front();
      if (got.step_level !== want.step_level || got.dir_level !== want.dir_level ||
          got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
          got.position !== want.position || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %s, got %s", describe(want), describe(got));
      end
    endfunction

    function int outstanding();
      return axis_reports.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CFG_INDEX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_wdata;

  smpg_in_if  in_ch ();
  smpg_out_if out_ch ();

  axis_scoreboard sb = new();
  result_t        seen_result;
  int             cycle_count = 0;
  int             hold_cycles = 0;
  int             burst_left = 0;
  int             items_sent = 0;

  stepper_move_pulse_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("stepper_move_pulse_generator_tb: FAIL");
    $finish;
  end

  // accepted commands first, so a result always finds its expectation queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.advance_axis(in_ch.action, in_ch.amount);
      if (out_ch.valid && out_ch.ready) begin
        seen_result.step_level = out_ch.step_level;
        seen_result.dir_level  = out_ch.dir_level;
        seen_result.busy_res   = out_ch.busy_res;
        seen_result.done_res   = out_ch.done_res;
        seen_result.position   = out_ch.position;
        seen_result.status     = status_t'(out_ch.status);
        sb.compare_report(seen_result);
      end
    end
  end

  // result side: stall rate changes per stretch, long holds on request
  initial begin
    int stretch;
    int stall_pct;
    out_ch.ready <= 1'b0;
    forever begin
      case ($urandom_range(4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stretch = $urandom_range(10, 150);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_cycles > 0) begin
          out_ch.ready <= 1'b0;
          hold_cycles--;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
      end
    end
  end

  task automatic offer(input logic [ACTION_BITS-1:0] act, input logic [AMOUNT_BITS-1:0] amt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.amount <= amt;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic await_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [HALF_PERIOD_BITS-1:0] hp,
                             input logic [HALF_PERIOD_BITS-1:0] floor_hp,
                             input logic pol);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_wdata <= hp;
    @(posedge clk);
    cfg_index <= REG_MIN_HALF_PERIOD;
    cfg_wdata <= floor_hp;
    @(posedge clk);
    cfg_index <= REG_DIR_POLARITY;
    cfg_wdata <= CFG_DATA_BITS'(pol);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_HALF_PERIOD, hp);
    sb.write_reg(REG_MIN_HALF_PERIOD, floor_hp);
    sb.write_reg(REG_DIR_POLARITY, CFG_DATA_BITS'(pol));
  endtask

  function automatic logic [AMOUNT_BITS-1:0] rand_amount();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return '0;
      4: return AMOUNT_BITS'($urandom_range(16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [AMOUNT_BITS-1:0] pick_position();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return AMOUNT_BITS'($urandom_range(4)) - 32'd2;
      default: return $urandom();
    endcase
  endfunction

  // move, then enough ticks to finish it if the half period is at most 8, with the odd interruption
  task automatic move_sequence();
    logic [HALF_PERIOD_BITS-1:0] h;
    logic [AMOUNT_BITS-1:0]      travel;
    int                          mag;
    int                          ticks;
    if (sb.in_motion && $urandom_range(9) < 7) offer(ACT_STOP, $urandom());
    if ($urandom_range(3) == 0) offer(ACT_SET_POS, pick_position());
    mag = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(MIN_MOVE_PULSES, 6);
    travel = $urandom_range(1) ? AMOUNT_BITS'(mag) : -AMOUNT_BITS'(mag);
    if ($urandom_range(1)) offer(ACT_REL, travel);
    else offer(ACT_ABS, sb.axis_pos + travel);
    h = sb.pulse_half();
    ticks = (h <= 8) ? mag * 2 * int'(h) + $urandom_range(3) : $urandom_range(1, 40);
    repeat (ticks) begin
      case ($urandom_range(39))
        0: offer(ACT_STOP, $urandom());
        1: offer(ACT_REL, rand_amount());
        2: offer(ACT_SET_POS, pick_position());
        3: offer(ACT_ABS, rand_amount());
        default: offer(ACT_TICK, $urandom());
      endcase
    end
    if (h > 8 && $urandom_range(1)) offer(ACT_STOP, $urandom());
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(9) < 7) begin
        move_sequence();
      end else begin
        repeat ($urandom_range(1, 6)) offer(ACTION_BITS'($urandom_range(7)), rand_amount());
      end
    end
  endtask

  task automatic run_phase(input logic [HALF_PERIOD_BITS-1:0] hp,
                           input logic [HALF_PERIOD_BITS-1:0] floor_hp,
                           input logic pol, input int n);
    await_idle();
    load_config(hp, floor_hp, pol);
    run_random(n);
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_TICK;
    in_ch.amount <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_HALF_PERIOD;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    offer(ACT_TICK, '0);
    offer(ACT_SET_POS, 32'h7FFF_FFFF);
    offer(ACT_REL, '0);
    offer(ACT_REL, 32'd1);
    offer(ACT_REL, 32'hFFFF_FFFF);
    // two pulses up across the sign boundary
    offer(ACT_ABS, 32'h8000_0001);
    offer(ACT_TICK, $urandom());
    offer(ACT_REL, 32'd5);
    offer(ACT_SET_POS, '0);
    offer(ACT_STOP, '0);
    offer(ACT_REL, 32'h8000_0000);
    offer(ACT_STOP, 32'hFFFF_FFFF);
    offer(ACT_UNDEFINED, 32'hA5A5_5A5A);
    offer(ACT_REL, 32'd2);
    offer(ACT_TICK, '0);
    offer(ACT_TICK, '0);
    await_idle();
    // shorter period while the phase count is already past it
    load_config(24'd1, 24'd1, 1'b1);
    repeat (3) offer(ACT_TICK, $urandom());
    offer(ACT_SET_POS, 32'h7FFF_FFFF);
    offer(ACT_REL, 32'd2);
    repeat (4) offer(ACT_TICK, $urandom());
    run_random(60);

    await_idle();
    load_config(24'd2, 24'd1, 1'b0);
    hold_cycles = 150;
    run_random(150);

    run_phase(24'd1, 24'd3, 1'b1, 130);
    run_phase(24'hFF_FFFF, 24'd1, 1'b0, 40);
    run_phase(24'd1, 24'hFF_FFFF, 1'b1, 40);
    run_phase(24'd4, 24'd2, 1'b1, 130);
    run_phase(24'd3, 24'd1, 1'b0, 120);
    run_phase(24'($urandom_range(1, 5)), 24'($urandom_range(1, 5)),
              1'($urandom_range(1)), 130);
    run_phase(24'd1, 24'd1, 1'b0, 130);
    await_idle();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("stepper_move_pulse_generator_tb: PASS");
    end else begin
      $display("stepper_move_pulse_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
